// ===== design/sxt_pkg.sv =====
// Shared types and constants for the S-expression tokenizer.
package sxt_pkg;

	localparam int MAX_LINE_DEF    = 1024;
	localparam int QUEUE_DEPTH_DEF = 4;

	localparam logic [7:0] CH_END    = 8'd0;
	localparam logic [7:0] CH_SPACE  = 8'd32;
	localparam logic [7:0] CH_TAB    = 8'd9;
	localparam logic [7:0] CH_CR     = 8'd13;
	localparam logic [7:0] CH_LPAREN = 8'd40;
	localparam logic [7:0] CH_RPAREN = 8'd41;
	localparam logic [7:0] CH_DOT    = 8'd46;
	localparam logic [7:0] CH_ZERO   = 8'd48;
	localparam logic [7:0] CH_NINE   = 8'd57;

	localparam logic [9:0] SAT10 = 10'd1023;

	typedef enum logic [2:0] {
		KIND_LPAREN  = 3'd0,
		KIND_RPAREN  = 3'd1,
		KIND_SYMBOL  = 3'd2,
		KIND_INTEGER = 3'd3,
		KIND_DOT     = 3'd4,
		KIND_END     = 3'd5
	} sxt_kind_t;

	typedef enum logic [1:0] {
		ERR_NONE     = 2'd0,
		ERR_BAD_INT  = 2'd1,
		ERR_TOO_LONG = 2'd2
	} sxt_err_t;

	typedef enum logic [1:0] {
		MODE_IDLE    = 2'd0,
		MODE_SYMBOL  = 2'd1,
		MODE_INTEGER = 2'd2,
		MODE_DISCARD = 2'd3
	} sxt_mode_t;

	typedef struct packed {
		sxt_kind_t   kind;
		sxt_err_t    err;
		logic [9:0]  start;
		logic [9:0]  length;
		logic [15:0] value;
		logic        last;
	} sxt_result_t;

	// One character's worth of results: one or two tokens.
	typedef struct packed {
		sxt_result_t r0;
		sxt_result_t r1;
		logic        two;
	} sxt_entry_t;

	typedef struct packed {
		logic       valid;
		sxt_entry_t entry;
	} sxt_head_t;

endpackage

// ===== design/sexpr_tokenizer_unit.sv =====
// A character's results are written to the queue and then registered at the output stage.
// Throughput: one character per cycle while the queue has room (in_ready); the output side moves
// one result per cycle while out_ready is high, so a character that closes a run with a parenthesis or
// end of line yields two results, absorbed by the QUEUE_DEPTH-entry queue between front end and output stage.
// Reset (arst_n low, asynchronous): scanner idle at position 0, queue and output empty.
module sexpr_tokenizer_unit #(
	parameter int MAX_LINE    = sxt_pkg::MAX_LINE_DEF,
	parameter int QUEUE_DEPTH = sxt_pkg::QUEUE_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  ch,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  token_kind,
	output logic [1:0]  error_code,
	output logic [9:0]  token_start,
	output logic [9:0]  token_length,
	output logic [15:0] int_value,
	output logic        last
);

	logic                 q_ready;
	logic                 push;
	logic                 pop;
	sxt_pkg::sxt_entry_t  entry;
	sxt_pkg::sxt_head_t   head;
	sxt_pkg::sxt_result_t result;

	assign in_ready = q_ready;

	sxt_front #(.MAX_LINE(MAX_LINE)) u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (in_valid && q_ready),
		.ch     (ch),
		.push   (push),
		.entry  (entry)
	);

	sxt_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.wr_entry (entry),
		.pop      (pop),
		.ready    (q_ready),
		.head     (head)
	);

	sxt_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.pop       (pop),
		.out_ready (out_ready),
		.out_valid (out_valid),
		.result    (result)
	);

	assign token_kind   = result.kind;
	assign error_code   = result.err;
	assign token_start  = result.start;
	assign token_length = result.length;
	assign int_value    = result.value;
	assign last         = result.last;

endmodule

// ===== design/sxt_front.sv =====
// Front end: character classification, scan state and token building.
module sxt_front #(
	parameter int MAX_LINE = sxt_pkg::MAX_LINE_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                accept,
	input  logic [7:0]          ch,
	output logic                push,
	output sxt_pkg::sxt_entry_t entry
);

	localparam int POS_W = $clog2(MAX_LINE + 1);
	localparam int WIDE_W = POS_W + 10;
	localparam int OVF_START = (MAX_LINE - 1 > 1023) ? 1023 : MAX_LINE - 1;

	sxt_pkg::sxt_mode_t mode_q, mode_d;
	logic [POS_W-1:0]   pos_q, pos_d;
	logic [9:0]         start_q, start_d;
	logic [9:0]         len_q, len_d;
	logic [15:0]        acc_q, acc_d;

	logic               is_sp, is_dg, is_lp, is_rp, is_delim;
	logic [WIDE_W-1:0]  pos_wide;
	logic [9:0]         pos_sat;
	logic [9:0]         len_inc;
	logic [15:0]        acc_next;
	logic [15:0]        digit;
	logic               run_open;
	logic               fa, fb;
	sxt_pkg::sxt_result_t tok_a, tok_b;

	assign is_sp    = (ch == sxt_pkg::CH_SPACE) ||
	                  (ch >= sxt_pkg::CH_TAB && ch <= sxt_pkg::CH_CR);
	assign is_dg    = (ch >= sxt_pkg::CH_ZERO) && (ch <= sxt_pkg::CH_NINE);
	assign is_lp    = (ch == sxt_pkg::CH_LPAREN);
	assign is_rp    = (ch == sxt_pkg::CH_RPAREN);
	assign is_delim = is_sp || is_lp || is_rp;

	assign pos_wide = WIDE_W'(pos_q);
	assign pos_sat  = (pos_wide > WIDE_W'(sxt_pkg::SAT10)) ? sxt_pkg::SAT10 : pos_wide[9:0];
	assign len_inc  = (len_q == sxt_pkg::SAT10) ? len_q : len_q + 10'd1;
	assign digit    = 16'(ch - sxt_pkg::CH_ZERO);
	// x10 as two shifts and an add, wraps mod 2^16
	assign acc_next = (acc_q << 3) + (acc_q << 1) + digit;
	assign run_open = (mode_q == sxt_pkg::MODE_SYMBOL) || (mode_q == sxt_pkg::MODE_INTEGER);

	always_comb begin
		mode_d  = mode_q;
		pos_d   = pos_q;
		start_d = start_q;
		len_d   = len_q;
		acc_d   = acc_q;
		fa      = 1'b0;
		fb      = 1'b0;

		// tok_a: the pending run (or the bad-integer report)
		tok_a.kind   = (mode_q == sxt_pkg::MODE_INTEGER) ? sxt_pkg::KIND_INTEGER
		                                                 : sxt_pkg::KIND_SYMBOL;
		tok_a.err    = sxt_pkg::ERR_NONE;
		tok_a.start  = start_q;
		tok_a.length = len_q;
		tok_a.value  = (mode_q == sxt_pkg::MODE_INTEGER) ? acc_q : 16'd0;
		tok_a.last   = 1'b0;

		// tok_b: single-character token, end marker or overflow report
		tok_b.kind   = sxt_pkg::KIND_END;
		tok_b.err    = sxt_pkg::ERR_NONE;
		tok_b.start  = pos_sat;
		tok_b.length = 10'd1;
		tok_b.value  = 16'd0;
		tok_b.last   = 1'b1;

		if (ch == sxt_pkg::CH_END) begin
			fa           = run_open;
			fb           = 1'b1;
			tok_b.length = 10'd0;
			mode_d       = sxt_pkg::MODE_IDLE;
			pos_d        = '0;
		end else begin
			if (mode_q != sxt_pkg::MODE_DISCARD && pos_q >= POS_W'(MAX_LINE)) begin
				fb           = 1'b1;
				tok_b.err    = sxt_pkg::ERR_TOO_LONG;
				tok_b.start  = 10'(OVF_START);
				tok_b.length = 10'd0;
				mode_d       = sxt_pkg::MODE_DISCARD;
			end else if (mode_q == sxt_pkg::MODE_INTEGER && is_dg) begin
				len_d = len_inc;
				acc_d = acc_next;
			end else if (mode_q == sxt_pkg::MODE_INTEGER && !is_delim) begin
				fa        = 1'b1;
				tok_a.err = sxt_pkg::ERR_BAD_INT;
				mode_d    = sxt_pkg::MODE_DISCARD;
			end else if (mode_q == sxt_pkg::MODE_SYMBOL && !is_delim) begin
				len_d = len_inc;
			end else if (mode_q != sxt_pkg::MODE_DISCARD) begin
				fa     = run_open;
				mode_d = sxt_pkg::MODE_IDLE;
				if (is_lp) begin
					fb         = 1'b1;
					tok_b.kind = sxt_pkg::KIND_LPAREN;
				end else if (is_rp) begin
					fb         = 1'b1;
					tok_b.kind = sxt_pkg::KIND_RPAREN;
				end else if (is_sp || run_open) begin
					// whitespace, or a run just closed by it
				end else if (ch == sxt_pkg::CH_DOT) begin
					fb         = 1'b1;
					tok_b.kind = sxt_pkg::KIND_DOT;
				end else begin
					mode_d  = is_dg ? sxt_pkg::MODE_INTEGER : sxt_pkg::MODE_SYMBOL;
					start_d = pos_sat;
					len_d   = 10'd1;
					acc_d   = is_dg ? digit : 16'd0;
				end
			end
			if (pos_q < POS_W'(MAX_LINE))
				pos_d = pos_q + POS_W'(1);
		end
	end

	always_comb begin
		push      = accept && (fa || fb);
		entry.two = fa && fb;
		entry.r0  = fa ? tok_a : tok_b;
		entry.r0.last = !(fa && fb);
		entry.r1  = tok_b;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= sxt_pkg::MODE_IDLE;
			pos_q   <= '0;
			start_q <= '0;
			len_q   <= '0;
			acc_q   <= '0;
		end else if (accept) begin
			mode_q  <= mode_d;
			pos_q   <= pos_d;
			start_q <= start_d;
			len_q   <= len_d;
			acc_q   <= acc_d;
		end
	end

endmodule

// ===== design/sxt_queue.sv =====
// Small result queue between the front end and the output stage.
module sxt_queue #(
	parameter int DEPTH = sxt_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  sxt_pkg::sxt_entry_t wr_entry,
	input  logic                pop,
	output logic                ready,
	output sxt_pkg::sxt_head_t  head
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	sxt_pkg::sxt_entry_t mem_q [DEPTH];
	logic [PTR_W-1:0]    wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0]    count_q;
	logic                do_pop;

	assign ready      = (count_q < CNT_W'(DEPTH));
	assign head.valid = (count_q != '0);
	assign head.entry = mem_q[rd_ptr_q];
	assign do_pop     = pop && head.valid;

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= wr_entry;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			if (do_pop)
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			if (push && !do_pop)
				count_q <= count_q + CNT_W'(1);
			else if (!push && do_pop)
				count_q <= count_q - CNT_W'(1);
		end
	end

endmodule

// ===== design/sxt_back.sv =====
// Output stage: splits queue entries into single results on the output channel.
module sxt_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  sxt_pkg::sxt_head_t   head,
	output logic                 pop,
	input  logic                 out_ready,
	output logic                 out_valid,
	output sxt_pkg::sxt_result_t result
);

	logic                 out_valid_q;
	sxt_pkg::sxt_result_t out_q;
	logic                 pend_q;
	sxt_pkg::sxt_result_t pend_data_q;
	logic                 take;

	assign take      = !out_valid_q || out_ready;
	assign pop       = take && !pend_q && head.valid;
	assign out_valid = out_valid_q;
	assign result    = out_q;

	always_ff @(posedge clk) begin
		if (take) begin
			if (pend_q)
				out_q <= pend_data_q;
			else if (head.valid) begin
				out_q       <= head.entry.r0;
				pend_data_q <= head.entry.r1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			pend_q      <= 1'b0;
		end else if (take) begin
			if (pend_q) begin
				out_valid_q <= 1'b1;
				pend_q      <= 1'b0;
			end else if (head.valid) begin
				out_valid_q <= 1'b1;
				pend_q      <= head.entry.two;
			end else begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// ===== design/sxt_checker.sv =====
// Port-level checks for the tokenizer, bound to the top level.
module sxt_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic [2:0]  token_kind,
	input logic [1:0]  error_code,
	input logic [9:0]  token_length,
	input logic [15:0] int_value,
	input logic        last
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(token_kind) &&
		$stable(token_length) && $stable(int_value) && $stable(last))
		else $error("output transfer dropped or changed while stalled");

	a_end_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && token_kind == sxt_pkg::KIND_END |->
		last && token_length == 10'd0 && int_value == 16'd0)
		else $error("end marker malformed or not last");

	a_err_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && error_code != sxt_pkg::ERR_NONE |-> last)
		else $error("error result not last for its character");

	a_single: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (token_kind == sxt_pkg::KIND_LPAREN ||
		token_kind == sxt_pkg::KIND_RPAREN || token_kind == sxt_pkg::KIND_DOT) |->
		token_length == 10'd1 && error_code == sxt_pkg::ERR_NONE && last)
		else $error("single-character token malformed");

	a_value: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && token_kind != sxt_pkg::KIND_INTEGER |-> int_value == 16'd0)
		else $error("value on non-integer token");

endmodule

bind sexpr_tokenizer_unit sxt_checker u_sxt_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.out_valid    (out_valid),
	.out_ready    (out_ready),
	.token_kind   (token_kind),
	.error_code   (error_code),
	.token_length (token_length),
	.int_value    (int_value),
	.last         (last)
);
